### src/exif_oe_pkg.sv
package exif_oe_pkg;

	// Width of the TIFF-relative position counter
	localparam int POS_BITS = 16;
	// Skip targets carry one extra bit so that a target past the counter range never matches
	localparam int TGT_BITS = POS_BITS + 1;

	localparam logic [POS_BITS-1:0] POS_MAX      = {POS_BITS{1'b1}};
	localparam logic [32:0]         POS_MAX_WIDE = (33'd1 << POS_BITS) - 33'd1;

	localparam logic [31:0] TIFF_MAGIC      = 32'd42;
	localparam logic [31:0] ORDER_BIG       = 32'h0000_4D4D;
	localparam logic [31:0] ORDER_LITTLE    = 32'h0000_4949;
	localparam logic [31:0] IFD_MIN_OFFSET  = 32'd8;
	localparam logic [31:0] TAG_ORIENTATION = 32'h0000_0112;
	localparam logic [31:0] TYPE_SHORT      = 32'd3;
	localparam logic [31:0] ORIENT_MAX      = 32'd8;
	localparam int          SIG_LEN         = 6;
	localparam int          ENTRY_REST      = 10;

	typedef enum logic [3:0] {
		PH_SIG    = 4'd0,
		PH_ORDER  = 4'd1,
		PH_MAGIC  = 4'd2,
		PH_IFDOFF = 4'd3,
		PH_SKIP   = 4'd4,
		PH_COUNT  = 4'd5,
		PH_TAG    = 4'd6,
		PH_ESKIP  = 4'd7,
		PH_TYPE   = 4'd8,
		PH_VCOUNT = 4'd9,
		PH_VALUE  = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		OUT_FOUND = 2'd0,
		OUT_NONE  = 2'd1,
		OUT_ERROR = 2'd2
	} outcome_t;

	// Result of one item as handed from the parser to the result register
	typedef struct packed {
		logic     emit;
		outcome_t outcome;
		logic [3:0] orientation;
	} res_t;

	// Expected signature byte at a given index ("Exif" followed by two zeros)
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = 8'h45;
			3'd1: v = 8'h78;
			3'd2: v = 8'h69;
			3'd3: v = 8'h66;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Byte length of the field read in a phase; zero for skip phases
	function automatic logic [2:0] field_len(input phase_t ph);
		logic [2:0] n;
		case (ph)
			PH_IFDOFF, PH_VCOUNT: n = 3'd4;
			PH_ORDER, PH_MAGIC, PH_COUNT, PH_TAG, PH_TYPE, PH_VALUE: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

### src/exif_oe_byte_if.sv
interface exif_oe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       end_of_buffer;

	modport source (output valid, output payload_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input payload_byte, input end_of_buffer, output ready);
endinterface

### src/exif_oe_result_if.sv
interface exif_oe_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] outcome;
	logic [3:0] orientation_value;

	modport source (output valid, output outcome, output orientation_value, input ready);
	modport sink   (input valid, input outcome, input orientation_value, output ready);
endinterface

### src/exif_oe_parser.sv
module exif_oe_parser
	import exif_oe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] payload_byte,
	input  logic       end_of_buffer,
	output res_t       res
);

	phase_t                phase_q, phase_n;
	logic [POS_BITS-1:0]   pos_q, pos_n;
	logic                  big_q, big_n;
	logic [31:0]           acc_q, acc_n;
	logic [TGT_BITS-1:0]   tgt_q, tgt_n;
	logic [15:0]           ent_q, ent_n;
	logic                  given_q, given_n;

	logic                  decided;
	outcome_t              code;
	logic [3:0]            val;
	logic [2:0]            len;

	// Next state: one byte advances the phase machine
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		big_n   = big_q;
		acc_n   = acc_q;
		tgt_n   = tgt_q;
		ent_n   = ent_q;
		given_n = given_q;
		decided = 1'b0;
		code    = OUT_ERROR;
		val     = 4'd0;
		len     = field_len(phase_q);

		if (given_q) begin
			// result already out: drop bytes until the end of this payload
		end else if (phase_q == PH_SIG) begin
			if (pos_q[2:0] > 3'(SIG_LEN - 1) || payload_byte != sig_byte(pos_q[2:0])) begin
				decided = 1'b1;
			end else begin
				pos_n = pos_q + POS_BITS'(1);
				if (pos_n == POS_BITS'(SIG_LEN)) begin
					pos_n   = '0;
					phase_n = PH_ORDER;
					acc_n   = '0;
					tgt_n   = TGT_BITS'(2);
				end
			end
		end else if (pos_q == POS_MAX) begin
			decided = 1'b1;
		end else begin
			pos_n = pos_q + POS_BITS'(1);
			// assemble the multi-byte field in the current byte order
			if (len != 3'd0) begin
				if (phase_q == PH_ORDER || big_q) begin
					acc_n = {acc_q[23:0], payload_byte};
				end else if (len == 3'd4) begin
					acc_n = {payload_byte, acc_q[31:8]};
				end else begin
					acc_n = {16'd0, payload_byte, acc_q[15:8]};
				end
			end
			// field or skip complete: check it and pick the next phase
			if ({1'b0, pos_n} == TGT_BITS'(tgt_q)) begin
				case (phase_q)
					PH_ORDER: begin
						if (acc_n == ORDER_BIG || acc_n == ORDER_LITTLE) begin
							big_n   = (acc_n == ORDER_BIG);
							phase_n = PH_MAGIC;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(2);
						end else begin
							decided = 1'b1;
						end
					end
					PH_MAGIC: begin
						if (acc_n != TIFF_MAGIC) begin
							decided = 1'b1;
						end else begin
							phase_n = PH_IFDOFF;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(4);
						end
					end
					PH_IFDOFF: begin
						if (acc_n < IFD_MIN_OFFSET || {1'b0, acc_n} > POS_MAX_WIDE) begin
							decided = 1'b1;
						end else if (acc_n == IFD_MIN_OFFSET) begin
							phase_n = PH_COUNT;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(2);
						end else begin
							phase_n = PH_SKIP;
							tgt_n   = TGT_BITS'(acc_n);
						end
					end
					PH_SKIP: begin
						phase_n = PH_COUNT;
						acc_n   = '0;
						tgt_n   = {1'b0, pos_n} + TGT_BITS'(2);
					end
					PH_COUNT: begin
						ent_n = acc_n[15:0];
						if (ent_n == 16'd0) begin
							decided = 1'b1;
							code    = OUT_NONE;
						end else begin
							phase_n = PH_TAG;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(2);
						end
					end
					PH_TAG: begin
						if (acc_n > TAG_ORIENTATION) begin
							decided = 1'b1;
							code    = OUT_NONE;
						end else if (acc_n < TAG_ORIENTATION) begin
							phase_n = PH_ESKIP;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(ENTRY_REST);
						end else begin
							phase_n = PH_TYPE;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(2);
						end
					end
					PH_ESKIP: begin
						ent_n = ent_q - 16'd1;
						if (ent_n == 16'd0) begin
							decided = 1'b1;
							code    = OUT_NONE;
						end else begin
							phase_n = PH_TAG;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(2);
						end
					end
					PH_TYPE: begin
						if (acc_n != TYPE_SHORT) begin
							decided = 1'b1;
						end else begin
							phase_n = PH_VCOUNT;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(4);
						end
					end
					PH_VCOUNT: begin
						if (acc_n != 32'd1) begin
							decided = 1'b1;
						end else begin
							phase_n = PH_VALUE;
							acc_n   = '0;
							tgt_n   = {1'b0, pos_n} + TGT_BITS'(2);
						end
					end
					PH_VALUE: begin
						decided = 1'b1;
						if (acc_n != 32'd0 && acc_n <= ORIENT_MAX) begin
							code = OUT_FOUND;
							val  = acc_n[3:0];
						end
					end
					default: begin
						decided = 1'b1;
					end
				endcase
			end
		end

		if (decided) begin
			given_n = 1'b1;
		end
		// end of payload: restart at the signature
		if (end_of_buffer) begin
			phase_n = PH_SIG;
			pos_n   = '0;
			big_n   = 1'b0;
			acc_n   = '0;
			tgt_n   = '0;
			ent_n   = '0;
			given_n = 1'b0;
		end
	end

	// Outputs: a decision, or an early end of payload, yields one result
	always_comb begin
		res.emit        = !given_q && (decided || end_of_buffer);
		res.outcome     = decided ? code : OUT_ERROR;
		res.orientation = (decided && code == OUT_FOUND) ? val : 4'd0;
	end

	// Hold parser state between bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			pos_q   <= '0;
			big_q   <= 1'b0;
			acc_q   <= '0;
			tgt_q   <= '0;
			ent_q   <= '0;
			given_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			big_q   <= big_n;
			acc_q   <= acc_n;
			tgt_q   <= tgt_n;
			ent_q   <= ent_n;
			given_q <= given_n;
		end
	end

endmodule

### src/exif_oe_orientation_extractor.sv
// Channel   Dir  Payload                               Role
// bytes     in   payload_byte[7:0], end_of_buffer      EXIF payload, one byte per item
// result    out  outcome[1:0], orientation_value[3:0]  one item per payload decision
//
// One byte per cycle while result is not stalled; a byte's result passes through
// the input register, then the phase machine into the result register.
// arst_n clears the input and result valid flags and returns the parser to the signature phase.
// A stall on result holds the waiting byte in the input register; bytes keep flowing
// while the result register is empty or is being taken.
module exif_orientation_extractor
	import exif_oe_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	exif_oe_byte_if.sink            bytes,
	exif_oe_result_if.source        result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       advance;
	res_t       res;

	logic       out_valid_q;
	outcome_t   outcome_q;
	logic [3:0] orient_q;

	// The buffered byte moves on when the result register can take its result
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign bytes.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.payload_byte;
			eob_s1  <= bytes.end_of_buffer;
		end
	end

	exif_oe_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.payload_byte  (byte_s1),
		.end_of_buffer (eob_s1),
		.res           (res)
	);

	// Result register: load on a byte that emits a result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			outcome_q <= res.outcome;
			orient_q  <= res.orientation;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.outcome           = outcome_q;
	assign result.orientation_value = orient_q;

	// A stalled result keeps the buffered byte in place
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result.ready |=> valid_s1 && $stable(byte_s1))
		else $error("buffered byte lost while result stalled");

	// An empty input register always takes a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> bytes.ready)
		else $error("input stalled with empty input register");

	// Orientation is non-zero exactly when it was found, and then within range
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.outcome == OUT_FOUND) == (result.orientation_value != 4'd0))
			&& result.orientation_value <= 4'd8)
		else $error("orientation value inconsistent with outcome");

	// A result never appears without a byte having been processed
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result appeared without a processed byte");

endmodule
